// ===== rtl/dkpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dkpt_pkg
// Types and codes shared by the dual-key pending table modules.
// ----------------------------------------------------------------------------
package dkpt_pkg;

    // Operation codes on the input channel.
    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_FIND_OUT = 3'd1;
    localparam logic [2:0] OP_FIND_IN  = 3'd2;
    localparam logic [2:0] OP_REL_OUT  = 3'd3;
    localparam logic [2:0] OP_REL_IN   = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Class that the front end assigns to each item.
    typedef enum logic [1:0] {
        CLS_INSERT,
        CLS_FIND,
        CLS_RELEASE,
        CLS_REJECT
    } cls_t;

    // Classified item as it travels from the front end to the back end.
    typedef struct packed {
        cls_t         cls;
        logic         by_out;
        logic [31:0]  ib;
        logic [63:0]  ob;
        logic [7:0]   hd;
        logic [63:0]  tag;
        logic [31:0]  tmo;
        logic [63:0]  start;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic         status;
        logic [3:0]   idx;
        logic [31:0]  ib;
        logic [63:0]  ob;
        logic [7:0]   hd;
        logic [63:0]  tag;
        logic [31:0]  tmo;
        logic [63:0]  start;
        logic [4:0]   occ;
        logic         full;
    } res_t;

endpackage

// ===== rtl/dkpt_ram.sv =====
// ----------------------------------------------------------------------------
// dkpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dkpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dkpt_queue.sv =====
// ----------------------------------------------------------------------------
// dkpt_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dkpt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             push, pop;

    assign in_ready  = (fill_reg != CW'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/dkpt_front.sv =====
// ----------------------------------------------------------------------------
// dkpt_front
// Front end: takes input items and classifies them before they are queued.
// ----------------------------------------------------------------------------
module dkpt_front
    import dkpt_pkg::*;
#(
    parameter int HANDLER_BITS = 8
) (
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_inbound_key,
    input  logic [63:0] s_outbound_key,
    input  logic [7:0]  s_handler_handle,
    input  logic [63:0] s_tag_value,
    input  logic [31:0] s_timeout_value,
    input  logic [63:0] s_start_time,
    output logic        push_valid,
    input  logic        push_ready,
    output cmd_t        push_cmd
);

    localparam logic [7:0] HD_MASK =
        (HANDLER_BITS >= 8) ? 8'hFF : 8'((1 << HANDLER_BITS) - 1);

    logic [7:0] hd_masked;
    logic       ob_zero;

    assign hd_masked  = s_handler_handle & HD_MASK;
    assign ob_zero    = (s_outbound_key == '0);
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

    always_comb begin
        push_cmd.ib     = s_inbound_key;
        push_cmd.ob     = s_outbound_key;
        push_cmd.hd     = hd_masked;
        push_cmd.tag    = s_tag_value;
        push_cmd.tmo    = s_timeout_value;
        push_cmd.start  = s_start_time;
        push_cmd.by_out = 1'b0;
        push_cmd.cls    = CLS_REJECT;
        // Items that can never succeed are marked here so the back end skips the scan.
        case (s_operation)
            OP_INSERT: begin
                if (hd_masked != '0 && !ob_zero) begin
                    push_cmd.cls = CLS_INSERT;
                end
            end
            OP_FIND_OUT: begin
                push_cmd.by_out = 1'b1;
                if (!ob_zero) begin
                    push_cmd.cls = CLS_FIND;
                end
            end
            OP_FIND_IN: begin
                push_cmd.cls = CLS_FIND;
            end
            OP_REL_OUT: begin
                push_cmd.by_out = 1'b1;
                if (!ob_zero) begin
                    push_cmd.cls = CLS_RELEASE;
                end
            end
            OP_REL_IN: begin
                push_cmd.cls = CLS_RELEASE;
            end
            default: begin
                push_cmd.cls = CLS_REJECT;
            end
        endcase
    end

endmodule

// ===== rtl/dkpt_back.sv =====
// ----------------------------------------------------------------------------
// dkpt_back
// Back end: scans the key memory, then inserts, finds or releases an entry.
// ----------------------------------------------------------------------------
module dkpt_back
    import dkpt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 16,
    parameter int HANDLER_BITS = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic out_valid,
    input  logic out_ready,
    output res_t out
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HS = (HANDLER_BITS < 8) ? HANDLER_BITS : 8;
    localparam int KW = 96;
    localparam int PW = HS + 160;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_READ,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [IW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    logic                   dup_reg, dup_next;
    logic                   hit_found_reg, hit_found_next;
    logic [IW-1:0]          hit_idx_reg, hit_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0]          count_reg, count_next;
    res_t                   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;

    logic          key_we;
    logic [IW-1:0] key_raddr;
    logic [KW-1:0] key_wdata, key_rdata;
    logic [PW-1:0] pay_wdata, pay_rdata;
    logic          ent_valid, ib_hit, ob_hit, key_hit;
    res_t          fail_res;

    assign key_wdata = {cmd_reg.ib, cmd_reg.ob};
    assign pay_wdata = {cmd_reg.hd[HS-1:0], cmd_reg.tag, cmd_reg.tmo, cmd_reg.start};
    assign key_raddr = (state_reg == S_COMMIT) ? hit_idx_reg : scan_reg[IW-1:0];

    dkpt_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (free_idx_reg),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    dkpt_ram #(
        .WIDTH (PW),
        .DEPTH (TABLE_DEPTH)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (free_idx_reg),
        .wdata (pay_wdata),
        .raddr (hit_idx_reg),
        .rdata (pay_rdata)
    );

    assign ent_valid = valid_reg[chk_idx_reg];
    assign ib_hit    = (key_rdata[95:64] == cmd_reg.ib);
    assign ob_hit    = (key_rdata[63:0] == cmd_reg.ob);
    assign key_hit   = cmd_reg.by_out ? ob_hit : ib_hit;

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out       = out_reg;

    always_comb begin
        fail_res        = '0;
        fail_res.status = STATUS_FAIL;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scan_next       = scan_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        dup_next        = dup_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        key_we          = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next        = cmd;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    dup_next        = 1'b0;
                    hit_found_next  = 1'b0;
                    if (cmd.cls == CLS_REJECT) begin
                        res_next   = fail_res;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // One address goes out per cycle; its data is checked in the following cycle.
                if (scan_reg < CW'(TABLE_DEPTH)) begin
                    scan_next      = scan_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg[IW-1:0];
                end
                if (chk_valid_reg) begin
                    if (!ent_valid) begin
                        if (!free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end else begin
                        if (ib_hit || ob_hit) begin
                            dup_next = 1'b1;
                        end
                        if (key_hit && !hit_found_reg) begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                        end
                    end
                    if (chk_idx_reg == IW'(TABLE_DEPTH - 1)) begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                res_next   = fail_res;
                state_next = S_DONE;
                case (cmd_reg.cls)
                    CLS_INSERT: begin
                        if (free_found_reg && !dup_reg) begin
                            key_we                   = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            count_next               = count_reg + 1'b1;
                            res_next.status          = STATUS_OK;
                            res_next.idx             = 4'(free_idx_reg);
                        end
                    end
                    CLS_FIND: begin
                        if (hit_found_reg) begin
                            state_next = S_READ;
                        end
                    end
                    CLS_RELEASE: begin
                        if (hit_found_reg) begin
                            valid_next[hit_idx_reg] = 1'b0;
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                            res_next.status = STATUS_OK;
                            res_next.idx    = 4'(hit_idx_reg);
                        end
                    end
                    default: begin
                        res_next = fail_res;
                    end
                endcase
            end
            S_READ: begin
                res_next        = '0;
                res_next.status = STATUS_OK;
                res_next.idx    = 4'(hit_idx_reg);
                res_next.ib     = key_rdata[95:64];
                res_next.ob     = key_rdata[63:0];
                res_next.hd     = 8'(pay_rdata[PW-1 -: HS]);
                res_next.tag    = pay_rdata[159:96];
                res_next.tmo    = pay_rdata[95:64];
                res_next.start  = pay_rdata[63:0];
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_next       = res_reg;
                    out_next.occ   = 5'(count_reg);
                    out_next.full  = (count_reg == CW'(TABLE_DEPTH));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            chk_valid_reg  <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chk_valid_reg  <= chk_valid_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
        cmd_reg        <= cmd_next;
        scan_reg       <= scan_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        dup_reg        <= dup_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

// ===== rtl/dual_key_pending_table_core.sv =====
// ----------------------------------------------------------------------------
// dual_key_pending_table_core
// Table of outstanding requests reached by inbound slot or outbound id.
// ----------------------------------------------------------------------------
// Each item produces exactly one result item. Items are classified on entry and
// wait in a two-deep queue; the back end then walks the key memory one entry per
// cycle for an insert, find or release, and a successful find then reads the
// payload memory. Items that cannot succeed (unknown code, zero handler or zero
// outbound id) skip the walk. A finished result waits in an output register
// while the next item is worked on. The valid marks are cleared by reset; no
// clearing pass over the memories runs.
module dual_key_pending_table_core
    import dkpt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 16,
    parameter int HANDLER_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_inbound_key,
    input  logic [63:0] s_outbound_key,
    input  logic [7:0]  s_handler_handle,
    input  logic [63:0] s_tag_value,
    input  logic [31:0] s_timeout_value,
    input  logic [63:0] s_start_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [3:0]  m_entry_index,
    output logic [31:0] m_found_inbound,
    output logic [63:0] m_found_outbound,
    output logic [7:0]  m_found_handler,
    output logic [63:0] m_found_tag,
    output logic [31:0] m_found_timeout,
    output logic [63:0] m_found_start,
    output logic [4:0]  m_occupancy,
    output logic        m_is_full
);

    localparam int QW = $bits(cmd_t);

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;
    res_t res;

    dkpt_front #(
        .HANDLER_BITS (HANDLER_BITS)
    ) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_inbound_key    (s_inbound_key),
        .s_outbound_key   (s_outbound_key),
        .s_handler_handle (s_handler_handle),
        .s_tag_value      (s_tag_value),
        .s_timeout_value  (s_timeout_value),
        .s_start_time     (s_start_time),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_cmd         (push_cmd)
    );

    dkpt_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_cmd),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_cmd)
    );

    dkpt_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .HANDLER_BITS (HANDLER_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out       (res)
    );

    assign m_status         = res.status;
    assign m_entry_index    = res.idx;
    assign m_found_inbound  = res.ib;
    assign m_found_outbound = res.ob;
    assign m_found_handler  = res.hd;
    assign m_found_tag      = res.tag;
    assign m_found_timeout  = res.tmo;
    assign m_found_start    = res.start;
    assign m_occupancy      = res.occ;
    assign m_is_full        = res.full;

    // A failed item reports no position and no entry contents.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> (m_entry_index == 4'd0) && (m_found_handler == 8'd0)
            && (m_found_tag == 64'd0) && (m_found_start == 64'd0))
        else $error("failed result carries entry data");

    // Entry contents only come from a successful find, whose entry has a nonzero id.
    a_found_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_found_handler != 8'd0) |-> !m_status && (m_found_outbound != 64'd0))
        else $error("found handler without a valid stored entry");

    // The full flag agrees with the reported occupancy.
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_full |-> (m_occupancy == 5'(TABLE_DEPTH)))
        else $error("full flag disagrees with occupancy");

endmodule

// ===== sim/dkpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkpt_checker
// Watches both channels of the pending table, predicts each result item from
// its own copy of the table and compares the result items field by field.
// ----------------------------------------------------------------------------
module dkpt_checker
    import dkpt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 16,
    parameter int HANDLER_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_inbound_key,
    input  logic [63:0] s_outbound_key,
    input  logic [7:0]  s_handler_handle,
    input  logic [63:0] s_tag_value,
    input  logic [31:0] s_timeout_value,
    input  logic [63:0] s_start_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_status,
    input  logic [3:0]  m_entry_index,
    input  logic [31:0] m_found_inbound,
    input  logic [63:0] m_found_outbound,
    input  logic [7:0]  m_found_handler,
    input  logic [63:0] m_found_tag,
    input  logic [31:0] m_found_timeout,
    input  logic [63:0] m_found_start,
    input  logic [4:0]  m_occupancy,
    input  logic        m_is_full,
    output int          mismatch_count,
    output int          pending_results
);

    typedef struct {
        logic [31:0] ib;
        logic [63:0] ob;
        logic [7:0]  hd;
        logic [63:0] tag;
        logic [31:0] tmo;
        logic [63:0] start;
    } request_t;

    localparam logic [7:0] HANDLER_MASK =
        (HANDLER_BITS >= 8) ? 8'hFF : 8'((1 << HANDLER_BITS) - 1);

    request_t    requests [TABLE_DEPTH];
    bit          held [TABLE_DEPTH];
    int unsigned live_count;
    res_t        awaited_results [$];

    // Lowest held entry whose selected key matches; an outbound id of zero
    // never matches.
    function automatic int lookup_request(bit by_out, logic [31:0] ib, logic [63:0] ob);
        int i;
        if (by_out && ob == '0)
            return -1;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (held[i] && (by_out ? requests[i].ob == ob : requests[i].ib == ib))
                return i;
        end
        return -1;
    endfunction

    task automatic apply_request_op(output res_t res);
        logic [7:0] hd;
        int         slot;
        int         free_at;
        bit         dup;
        int         i;
        hd   = s_handler_handle & HANDLER_MASK;
        res  = '0;
        res.status = STATUS_FAIL;
        slot = -1;
        case (s_operation)
            OP_INSERT: begin
                if (hd != '0 && s_outbound_key != '0 && live_count < TABLE_DEPTH) begin
                    dup     = 0;
                    free_at = -1;
                    for (i = 0; i < TABLE_DEPTH; i++) begin
                        if (!held[i]) begin
                            if (free_at < 0)
                                free_at = i;
                        end else if (requests[i].ib == s_inbound_key ||
                                     requests[i].ob == s_outbound_key) begin
                            dup = 1;
                        end
                    end
                    if (!dup && free_at >= 0) begin
                        held[free_at]     = 1;
                        requests[free_at] = '{s_inbound_key, s_outbound_key, hd,
                                              s_tag_value, s_timeout_value, s_start_time};
                        live_count++;
                        slot = free_at;
                    end
                end
            end
            OP_FIND_OUT, OP_FIND_IN: begin
                slot = lookup_request(s_operation == OP_FIND_OUT,
                                      s_inbound_key, s_outbound_key);
                if (slot >= 0) begin
                    res.ib    = requests[slot].ib;
                    res.ob    = requests[slot].ob;
                    res.hd    = requests[slot].hd;
                    res.tag   = requests[slot].tag;
                    res.tmo   = requests[slot].tmo;
                    res.start = requests[slot].start;
                end
            end
            OP_REL_OUT, OP_REL_IN: begin
                slot = lookup_request(s_operation == OP_REL_OUT,
                                      s_inbound_key, s_outbound_key);
                if (slot >= 0) begin
                    held[slot] = 0;
                    if (live_count > 0)
                        live_count--;
                end
            end
            default: ;
        endcase
        if (slot >= 0) begin
            res.status = STATUS_OK;
            res.idx    = 4'(slot);
        end
        res.occ  = 5'(live_count);
        res.full = (live_count >= TABLE_DEPTH);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                held[i] = 0;
            live_count = 0;
            awaited_results.delete();
        end else begin
            // Results always come from earlier items, so compare before adding.
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result item with no item outstanding", $realtime);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("entry_index", want.idx, m_entry_index);
                    check_field("found_inbound", want.ib, m_found_inbound);
                    check_field("found_outbound", want.ob, m_found_outbound);
                    check_field("found_handler", want.hd, m_found_handler);
                    check_field("found_tag", want.tag, m_found_tag);
                    check_field("found_timeout", want.tmo, m_found_timeout);
                    check_field("found_start", want.start, m_found_start);
                    check_field("occupancy", want.occ, m_occupancy);
                    check_field("is_full", want.full, m_is_full);
                end
            end
            if (s_valid && s_ready) begin
                apply_request_op(want);
                awaited_results.push_back(want);
            end
        end
        pending_results = awaited_results.size();
    end

endmodule

// ===== sim/tb_dual_key_pending_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_key_pending_table_core
// Drives directed and random table operations into the pending table.
// ----------------------------------------------------------------------------
// Random items draw their keys from small pools so that the table fills up,
// duplicates are refused and lookups hit. Insert-heavy and release-heavy
// phases alternate to sweep the occupancy from empty to full and back.
// Both sides idle at random except over one long stretch in the middle.
module tb_dual_key_pending_table_core;
    import dkpt_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int POOL_SIZE    = 20;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [31:0] s_inbound_key;
    logic [63:0] s_outbound_key;
    logic [7:0]  s_handler_handle;
    logic [63:0] s_tag_value;
    logic [31:0] s_timeout_value;
    logic [63:0] s_start_time;
    logic        m_valid;
    logic        m_ready;
    logic        m_status;
    logic [3:0]  m_entry_index;
    logic [31:0] m_found_inbound;
    logic [63:0] m_found_outbound;
    logic [7:0]  m_found_handler;
    logic [63:0] m_found_tag;
    logic [31:0] m_found_timeout;
    logic [63:0] m_found_start;
    logic [4:0]  m_occupancy;
    logic        m_is_full;

    int mismatch_count;
    int pending_results;
    bit steady_flow = 0;

    logic [31:0] inbound_pool  [POOL_SIZE];
    logic [63:0] outbound_pool [POOL_SIZE];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    dual_key_pending_table_core u_dut (.*);

    dkpt_checker u_check (.*);

    always @(posedge aclk)
        m_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 29);

    initial begin
        #2ms;
        $display("dual_key_pending_table_core test failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(logic [2:0] op, logic [31:0] ib, logic [63:0] ob,
                             logic [7:0] hd, logic [63:0] tag, logic [31:0] tmo,
                             logic [63:0] start);
        while (!steady_flow && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_inbound_key    <= ib;
        s_outbound_key   <= ob;
        s_handler_handle <= hd;
        s_tag_value      <= tag;
        s_timeout_value  <= tmo;
        s_start_time     <= start;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    initial begin
        logic [2:0]  op;
        logic [31:0] ib;
        logic [63:0] ob;
        logic [7:0]  hd;
        int          pick;
        bit          filling;

        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_operation      <= OP_INSERT;
        s_inbound_key    <= '0;
        s_outbound_key   <= '0;
        s_handler_handle <= '0;
        s_tag_value      <= '0;
        s_timeout_value  <= '0;
        s_start_time     <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Lookups and releases on an empty table; the count must stay at zero.
        send_item(OP_FIND_OUT, 32'd0, 64'd5, 8'd1, '0, '0, '0);
        send_item(OP_FIND_IN, 32'd0, 64'd5, 8'd1, '0, '0, '0);
        send_item(OP_REL_OUT, 32'd0, 64'd5, 8'd1, '0, '0, '0);
        send_item(OP_REL_IN, 32'd0, 64'd5, 8'd1, '0, '0, '0);
        // Inserts refused for a missing handler or a zero outbound id, then two that succeed.
        send_item(OP_INSERT, 32'd3, 64'd3, 8'd0, rand64(), $urandom, rand64());
        send_item(OP_INSERT, 32'd3, 64'd0, 8'd3, rand64(), $urandom, rand64());
        send_item(OP_INSERT, 32'd0, 64'd1, 8'd1, '0, '0, '0);
        send_item(OP_INSERT, '1, '1, 8'hFF, '1, '1, '1);
        // Duplicate inbound slot, then duplicate outbound id.
        send_item(OP_INSERT, 32'd0, 64'd7, 8'd2, rand64(), $urandom, rand64());
        send_item(OP_INSERT, 32'd5, '1, 8'd2, rand64(), $urandom, rand64());
        send_item(OP_FIND_OUT, 32'd9, '1, 8'd0, '0, '0, '0);
        send_item(OP_FIND_IN, 32'd0, 64'd9, 8'd0, '0, '0, '0);
        send_item(OP_FIND_OUT, 32'd0, 64'd0, 8'd1, '0, '0, '0);
        send_item(OP_REL_OUT, 32'd0, 64'd0, 8'd1, '0, '0, '0);
        for (int k = 1; k <= 3; k++)
            send_item(OP_REL_IN + 3'(k), 32'd0, 64'd1, 8'd1, rand64(), $urandom, rand64());
        send_item(OP_REL_IN, 32'd0, 64'd1, 8'd1, '0, '0, '0);
        // The freed lowest entry is taken again by the next insert.
        send_item(OP_INSERT, 32'h1234_5678, 64'd2, 8'h80, rand64(), $urandom, rand64());
        send_item(OP_REL_OUT, 32'd0, '1, 8'd1, '0, '0, '0);
        send_item(OP_FIND_IN, '1, 64'd2, 8'd1, '0, '0, '0);
        send_item(OP_FIND_IN, 32'h1234_5678, 64'd2, 8'd1, '0, '0, '0);
        send_item(OP_REL_IN, 32'h1234_5678, 64'd0, 8'd1, '0, '0, '0);
        send_item(OP_REL_IN, 32'h1234_5678, 64'd0, 8'd1, '0, '0, '0);

        for (int k = 0; k < POOL_SIZE; k++) begin
            inbound_pool[k]  = $urandom;
            outbound_pool[k] = rand64();
            if (outbound_pool[k] == '0)
                outbound_pool[k] = 64'd1;
        end
        inbound_pool[0] = '0;
        inbound_pool[1] = '1;

        filling = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 500 && n < 750);
            if (n % 80 == 0)
                filling = !filling || n == 0;
            pick = $urandom_range(99);
            if (filling)
                op = (pick < 55) ? OP_INSERT : (pick < 65) ? OP_FIND_OUT :
                     (pick < 75) ? OP_FIND_IN : (pick < 84) ? OP_REL_OUT :
                     (pick < 95) ? OP_REL_IN : OP_REL_IN + 3'($urandom_range(1, 3));
            else
                op = (pick < 20) ? OP_INSERT : (pick < 32) ? OP_FIND_OUT :
                     (pick < 44) ? OP_FIND_IN : (pick < 70) ? OP_REL_OUT :
                     (pick < 95) ? OP_REL_IN : OP_REL_IN + 3'($urandom_range(1, 3));
            ib = ($urandom_range(9) == 0) ? $urandom : inbound_pool[$urandom_range(POOL_SIZE - 1)];
            case ($urandom_range(29))
                0:       ob = '0;
                1, 2, 3: ob = rand64();
                default: ob = outbound_pool[$urandom_range(POOL_SIZE - 1)];
            endcase
            hd = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            send_item(op, ib, ob, hd, rand64(), $urandom, rand64());
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0)
            $display("dual_key_pending_table_core test passed");
        else
            $display("dual_key_pending_table_core test failed");
        $finish;
    end

endmodule
